### rtl/core/ssdp_pkg.sv
// Shared types and constants for the space separated decimal parser.
`default_nettype none

package ssdp_pkg;

	// Largest value a parsed integer may reach before it saturates.
	localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

	// Character codes the parser recognises.
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// Number of result slots in the output queue.
	localparam logic [1:0] QUEUE_SLOTS = 2'd2;

	// Parser phase.
	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	// One result transaction.
	typedef struct packed {
		logic [30:0] value;
		logic [3:0]  number_index;
		logic [15:0] chars_used;
		logic        final_res;
		logic        failed;
		logic        run_end;
	} result_t;

	// Builds a result with run_end cleared; the caller marks the last one.
	function automatic result_t make_result(input logic [30:0] val, input logic [3:0] idx,
			input logic [15:0] used, input logic fin, input logic fail);
		result_t r;
		r.value        = val;
		r.number_index = idx;
		r.chars_used   = used;
		r.final_res    = fin;
		r.failed       = fail;
		r.run_end      = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/ssdp_step.sv
// Combinational parse step: one character against the current parser state.
`default_nettype none

module ssdp_step #(
	parameter int COUNT_WIDTH = 16
) (
	input  var ssdp_pkg::phase_t  phase,
	input  wire  [30:0]           acc,
	input  wire  [4:0]            done,
	input  wire  [COUNT_WIDTH-1:0] cnt,
	input  wire  [4:0]            wanted,
	input  wire  [7:0]            character,
	input  wire                   text_end,
	output ssdp_pkg::phase_t      nxt_phase,
	output logic [30:0]           nxt_acc,
	output logic [4:0]            nxt_done,
	output logic [COUNT_WIDTH-1:0] nxt_cnt,
	output ssdp_pkg::result_t     res0,
	output ssdp_pkg::result_t     res1,
	output logic [1:0]            res_count
);

	logic              is_digit;
	logic [3:0]        digit;
	logic [34:0]       times_ten;

	assign is_digit  = (character >= ssdp_pkg::CHAR_ZERO) && (character <= ssdp_pkg::CHAR_NINE);
	assign digit     = 4'(character - ssdp_pkg::CHAR_ZERO);
	assign times_ten = ({4'b0, acc} << 3) + ({4'b0, acc} << 1);

	// The step follows the parse rules in order, at most two results.
	always_comb begin
		ssdp_pkg::phase_t  ph;
		logic [30:0]       ac;
		logic [4:0]        dn;
		logic [COUNT_WIDTH-1:0] cn;
		logic [1:0]        n;
		logic              fin;
		logic [34:0]       sum;
		ssdp_pkg::result_t r;

		ph  = phase;
		ac  = acc;
		dn  = done;
		cn  = cnt;
		n   = 2'd0;
		fin = 1'b0;
		sum = '0;
		r   = '0;
		res0 = '0;
		res1 = '0;

		// A non-digit closes the number in progress.
		if (ph == ssdp_pkg::PH_DIGITS && !is_digit) begin
			fin = ({1'b0, dn} + 6'd1) >= {1'b0, wanted};
			r = ssdp_pkg::make_result(ac, dn[3:0], 16'(cn), fin, 1'b0);
			if (n == 2'd0) res0 = r; else res1 = r;
			n  = n + 2'd1;
			dn = dn + 5'd1;
			ac = '0;
			ph = fin ? ssdp_pkg::PH_DONE : ssdp_pkg::PH_SKIP;
		end

		if (ph == ssdp_pkg::PH_DIGITS || (ph == ssdp_pkg::PH_SKIP && is_digit)) begin
			// Accumulate the digit with saturation.
			sum = ((ph == ssdp_pkg::PH_DIGITS) ? times_ten : 35'd0) + 35'(digit);
			ac  = (sum > 35'(ssdp_pkg::VALUE_MAX)) ? ssdp_pkg::VALUE_MAX : sum[30:0];
			ph  = ssdp_pkg::PH_DIGITS;
			if (cn != '1) cn = cn + 1'b1;
			if (text_end) begin
				fin = ({1'b0, dn} + 6'd1) >= {1'b0, wanted};
				r = ssdp_pkg::make_result(ac, dn[3:0], 16'(cn), fin, 1'b0);
				if (n == 2'd0) res0 = r; else res1 = r;
				n  = n + 2'd1;
				dn = dn + 5'd1;
				ph = fin ? ssdp_pkg::PH_DONE : ssdp_pkg::PH_SKIP;
			end
		end else if (ph == ssdp_pkg::PH_SKIP) begin
			// Spaces are consumed; anything else fails the parse.
			if (character == ssdp_pkg::CHAR_SPACE) begin
				if (cn != '1) cn = cn + 1'b1;
			end else begin
				r = ssdp_pkg::make_result('0, dn[3:0], 16'(cn), 1'b1, 1'b1);
				if (n == 2'd0) res0 = r; else res1 = r;
				n  = n + 2'd1;
				ph = ssdp_pkg::PH_DONE;
			end
		end

		// The text ended before enough numbers were read.
		if (text_end && ph == ssdp_pkg::PH_SKIP) begin
			r = ssdp_pkg::make_result('0, dn[3:0], 16'(cn), 1'b1, 1'b1);
			if (n == 2'd0) res0 = r; else res1 = r;
			n  = n + 2'd1;
			ph = ssdp_pkg::PH_DONE;
		end

		// Mark the last result of this character.
		if (n == 2'd1) res0.run_end = 1'b1;
		if (n == 2'd2) res1.run_end = 1'b1;

		// The end of the text returns the parser to its reset state.
		if (text_end) begin
			ph = ssdp_pkg::PH_SKIP;
			ac = '0;
			dn = '0;
			cn = '0;
		end

		nxt_phase = ph;
		nxt_acc   = ac;
		nxt_done  = dn;
		nxt_cnt   = cn;
		res_count = n;
	end

endmodule

`default_nettype wire

### rtl/core/space_separated_decimal_parser_top.sv
// Top level of the space separated decimal parser.
// Each accepted character is registered in the input stage, then its results in the output queue.
// Throughput: one character per cycle while its results fit in the queue; otherwise in_stall is raised.
// The rate is set by the two-slot output queue that the results of a character enter at once.
// Reset clears the parser state, the input stage and the queue; the count register count_q resets to 1.
`default_nettype none

module space_separated_decimal_parser_top #(
	parameter int MAX_INTEGERS = 16,
	parameter int COUNT_WIDTH  = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	// Configuration channel
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [4:0]  cfg_data,
	// Input channel
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  character,
	input  wire         text_end,
	// Output channel
	output logic        out_valid,
	input  wire         out_stall,
	output logic [30:0] value,
	output logic [3:0]  number_index,
	output logic [15:0] chars_used,
	output logic        final_res,
	output logic        failed,
	output logic        run_end
);

	logic [4:0]             count_q;
	logic [4:0]             wanted;

	logic                   valid_s1;
	logic [7:0]             char_s1;
	logic                   end_s1;

	ssdp_pkg::phase_t       phase_q;
	ssdp_pkg::phase_t       nxt_phase;
	logic [30:0]            acc_q;
	logic [30:0]            nxt_acc;
	logic [4:0]             done_q;
	logic [4:0]             nxt_done;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [COUNT_WIDTH-1:0] nxt_cnt;

	ssdp_pkg::result_t      res0;
	ssdp_pkg::result_t      res1;
	logic [1:0]             res_count;

	ssdp_pkg::result_t      slot0_q;
	ssdp_pkg::result_t      slot1_q;
	ssdp_pkg::result_t      slot0_d;
	ssdp_pkg::result_t      slot1_d;
	logic [1:0]             fill_q;
	logic [1:0]             fill_d;
	logic [1:0]             remain;
	logic                   pop;
	logic                   advance;
	logic                   accept;

	// The configuration register is always writable.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	// Effective count: zero acts as one, large values clamp to the maximum.
	always_comb begin
		if (count_q == 5'd0) begin
			wanted = 5'd1;
		end else if (32'(count_q) > MAX_INTEGERS) begin
			wanted = 5'(MAX_INTEGERS);
		end else begin
			wanted = count_q;
		end
	end

	// Queue handshake: a character moves on when all its results fit.
	assign pop       = (fill_q != 2'd0) && !out_stall;
	assign remain    = fill_q - {1'b0, pop};
	assign advance   = valid_s1 && ({1'b0, remain} + {1'b0, res_count} <= {1'b0, ssdp_pkg::QUEUE_SLOTS});
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= character;
			end_s1  <= text_end;
		end
	end

	// Parse step on the registered character.
	ssdp_step #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_step (
		.phase     (phase_q),
		.acc       (acc_q),
		.done      (done_q),
		.cnt       (cnt_q),
		.wanted    (wanted),
		.character (char_s1),
		.text_end  (end_s1),
		.nxt_phase (nxt_phase),
		.nxt_acc   (nxt_acc),
		.nxt_done  (nxt_done),
		.nxt_cnt   (nxt_cnt),
		.res0      (res0),
		.res1      (res1),
		.res_count (res_count)
	);

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ssdp_pkg::PH_SKIP;
			acc_q   <= '0;
			done_q  <= '0;
			cnt_q   <= '0;
		end else if (advance) begin
			phase_q <= nxt_phase;
			acc_q   <= nxt_acc;
			done_q  <= nxt_done;
			cnt_q   <= nxt_cnt;
		end
	end

	// Output queue: shift out the head, append new results behind the rest.
	always_comb begin
		ssdp_pkg::result_t head;

		head    = pop ? slot1_q : slot0_q;
		slot0_d = head;
		slot1_d = slot1_q;
		fill_d  = remain;
		if (advance) begin
			fill_d = remain + res_count;
			case (remain)
				2'd0: begin
					slot0_d = res0;
					slot1_d = res1;
				end
				2'd1: begin
					slot0_d = head;
					slot1_d = res0;
				end
				default: begin
					slot0_d = head;
					slot1_d = slot1_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
		end else begin
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		slot0_q <= slot0_d;
		slot1_q <= slot1_d;
	end

	// Output ports come straight from the head of the queue.
	assign out_valid    = (fill_q != 2'd0);
	assign value        = slot0_q.value;
	assign number_index = slot0_q.number_index;
	assign chars_used   = slot0_q.chars_used;
	assign final_res    = slot0_q.final_res;
	assign failed       = slot0_q.failed;
	assign run_end      = slot0_q.run_end;

endmodule

`default_nettype wire

### tb/ssdp_tb_pkg.sv
// Scoreboard class that predicts and checks the results of the decimal parser.
package ssdp_tb_pkg;

	import ssdp_pkg::*;

	// Tracks the parser state for each accepted character and checks each result transaction.
	class parse_scoreboard;
		int          max_integers;
		logic [4:0]  integer_count;
		phase_t      phase;
		logic [30:0] accumulator;
		int          numbers_done;
		logic [15:0] char_count;
		result_t     expected_q[$];
		int          mismatches;
		int          results_checked;
		int          chars_noted;

		function new(int max_ints);
			max_integers    = max_ints;
			integer_count   = 5'd1;
			mismatches      = 0;
			results_checked = 0;
			chars_noted     = 0;
			clear_text();
		endfunction

		// Every text starts from a clean parser state.
		function void clear_text();
			phase        = PH_SKIP;
			accumulator  = '0;
			numbers_done = 0;
			char_count   = '0;
		endfunction

		function void set_count(logic [4:0] n);
			integer_count = n;
		endfunction

		// A count of zero means one, and the count is capped at the build-time maximum.
		function int wanted_count();
			if (integer_count == 5'd0)
				return 1;
			if (int'(integer_count) > max_integers)
				return max_integers;
			return int'(integer_count);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void bump_counter();
			if (char_count != 16'hFFFF)
				char_count++;
		endfunction

		function void push_result(logic [30:0] val, int idx, logic fin, logic fail);
			result_t r;
			r.value        = val;
			r.number_index = idx[3:0];
			r.chars_used   = char_count;
			r.final_res    = fin;
			r.failed       = fail;
			r.run_end      = 1'b0;
			expected_q.push_back(r);
		endfunction

		// Works out the results caused by one accepted character.
		function void note_char(logic [7:0] c, logic e);
			logic            is_digit;
			logic            fin;
			longint unsigned next_val;
			int              first;
			is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
			first    = expected_q.size();
			chars_noted++;

			// A non-digit closes the number in progress; the character is then parsed afresh.
			if (phase == PH_DIGITS && !is_digit) begin
				fin = (numbers_done + 1 >= wanted_count());
				push_result(accumulator, numbers_done, fin, 1'b0);
				numbers_done++;
				accumulator = '0;
				phase = fin ? PH_DONE : PH_SKIP;
			end

			// Digits accumulate with saturation; the end of the text closes the number.
			if (phase == PH_DIGITS || (phase == PH_SKIP && is_digit)) begin
				next_val = (phase == PH_DIGITS) ? longint'(accumulator) * 10 : 0;
				next_val += longint'(c - CHAR_ZERO);
				accumulator = (next_val > longint'(VALUE_MAX)) ? VALUE_MAX : next_val[30:0];
				phase = PH_DIGITS;
				bump_counter();
				if (e) begin
					fin = (numbers_done + 1 >= wanted_count());
					push_result(accumulator, numbers_done, fin, 1'b0);
					numbers_done++;
					phase = fin ? PH_DONE : PH_SKIP;
				end
			end else if (phase == PH_SKIP) begin
				if (c == CHAR_SPACE) begin
					bump_counter();
				end else begin
					push_result('0, numbers_done, 1'b1, 1'b1);
					phase = PH_DONE;
				end
			end

			// The text ran out before enough numbers were read.
			if (e && phase == PH_SKIP) begin
				push_result('0, numbers_done, 1'b1, 1'b1);
				phase = PH_DONE;
			end

			if (expected_q.size() > first)
				expected_q[expected_q.size() - 1].run_end = 1'b1;

			if (e)
				clear_text();
		endfunction

		function void compare_field(string name, longint unsigned want, longint unsigned seen,
				realtime stamp);
			if (want != seen) begin
				$display("%0.1f ns: %s expected %0d, got %0d", stamp, name, want, seen);
				mismatches++;
			end
		endfunction

		// Compares one accepted result transaction with the oldest expectation.
		function void check_number(result_t got, realtime stamp);
			result_t want;
			if (expected_q.size() == 0) begin
				$display("%0.1f ns: expected no result, got value %0d index %0d final %0d failed %0d",
					stamp, got.value, got.number_index, got.final_res, got.failed);
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			results_checked++;
			compare_field("value", want.value, got.value, stamp);
			compare_field("number_index", want.number_index, got.number_index, stamp);
			compare_field("chars_used", want.chars_used, got.chars_used, stamp);
			compare_field("final_res", want.final_res, got.final_res, stamp);
			compare_field("failed", want.failed, got.failed, stamp);
			compare_field("run_end", want.run_end, got.run_end, stamp);
		endfunction
	endclass

endpackage

### tb/tb.sv
// Self-checking testbench for the space separated decimal parser top level.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ssdp_pkg::*;
	import ssdp_tb_pkg::*;

	localparam int MAX_INTEGERS  = 16;
	localparam int COUNT_WIDTH   = 16;
	localparam int RANDOM_ITEMS  = 1050;
	localparam int TAIL_TEXTS    = 8;
	localparam int SETTLE_CYCLES = 8;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  character;
	logic        text_end;
	logic        out_valid;
	logic        out_stall;
	logic [30:0] value;
	logic [3:0]  number_index;
	logic [15:0] chars_used;
	logic        final_res;
	logic        failed;
	logic        run_end;

	parse_scoreboard sb;
	logic [7:0]      text_buf[$];
	logic            quiet;
	logic            calm;
	int              texts_sent;
	int              settings_used;

	space_separated_decimal_parser_top #(
		.MAX_INTEGERS(MAX_INTEGERS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.character   (character),
		.text_end    (text_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value       (value),
		.number_index(number_index),
		.chars_used  (chars_used),
		.final_res   (final_res),
		.failed      (failed),
		.run_end     (run_end)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the length of the run.
	initial begin
		#10_000_000;
		$display("[space_separated_decimal_parser_top] ERROR");
		$finish;
	end

	// Output back-pressure in random bursts, switched off in the quiet part of the run.
	initial begin
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (quiet) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	// Each accepted result transaction goes to the scoreboard.
	always @(posedge clk) begin
		result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.value        = value;
			got.number_index = number_index;
			got.chars_used   = chars_used;
			got.final_res    = final_res;
			got.failed       = failed;
			got.run_end      = run_end;
			sb.check_number(got, $realtime);
		end
	end

	// Offers one character, with an occasional idle gap first, and waits for the transaction.
	task automatic send_char(logic [7:0] c, logic e);
		int gap;
		gap = 0;
		if (!quiet && !calm && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		character <= c;
		text_end  <= e;
		do @(posedge clk); while (in_stall);
		sb.note_char(c, e);
	endtask

	// Sends the buffered text; the last character carries text_end when the text is closed.
	task automatic send_text(logic close);
		foreach (text_buf[i])
			send_char(text_buf[i], close && (i == text_buf.size() - 1));
		if (close)
			texts_sent++;
	endtask

	task automatic send_string(string s, logic close);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(8'(s[i]));
		send_text(close);
	endtask

	// Drops the input valid and waits until every expected result has been seen.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(logic [4:0] n);
		cfg_valid <= 1'b1;
		cfg_data  <= n;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_count(n);
		settings_used++;
	endtask

	function automatic logic [7:0] digit_char();
		return CHAR_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// Any byte that is neither a digit nor a space.
	function automatic logic [7:0] stray_char();
		logic [7:0] c;
		do c = 8'($urandom); while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_SPACE);
		return c;
	endfunction

	// Mostly small counts, with the extremes and the out-of-range values mixed in.
	function automatic logic [4:0] pick_count();
		case ($urandom_range(0, 7))
			0: return 5'd0;
			1: return 5'd1;
			2: return 5'd16;
			3: return 5'd31;
			4: return 5'($urandom_range(17, 30));
			default: return 5'($urandom_range(1, 6));
		endcase
	endfunction

	// A text of space separated numbers, sometimes one short or one over, with varied tails.
	function automatic void build_wellformed();
		int n;
		int ndig;
		int pick;
		text_buf.delete();
		n = sb.wanted_count();
		pick = $urandom_range(0, 9);
		if (pick == 0 && n > 1)
			n--;
		else if (pick == 1)
			n++;
		for (int k = 0; k < n; k++) begin
			if (k > 0 && $urandom_range(0, 19) == 0)
				text_buf.push_back(stray_char());
			else
				repeat ((k == 0) ? $urandom_range(0, 2) : $urandom_range(1, 3))
					text_buf.push_back(CHAR_SPACE);
			ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 13) : $urandom_range(1, 4);
			if ($urandom_range(0, 7) == 0)
				text_buf.push_back(CHAR_ZERO);
			repeat (ndig) text_buf.push_back(digit_char());
		end
		case ($urandom_range(0, 3))
			0: ;
			1: repeat ($urandom_range(1, 2)) text_buf.push_back(CHAR_SPACE);
			2: text_buf.push_back(stray_char());
			default: repeat ($urandom_range(1, 4)) text_buf.push_back(8'($urandom));
		endcase
	endfunction

	// Short texts of arbitrary bytes, leaning towards spaces and digits.
	function automatic void build_noise();
		text_buf.delete();
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(0, 2))
				0: text_buf.push_back(CHAR_SPACE);
				1: text_buf.push_back(digit_char());
				default: text_buf.push_back(8'($urandom));
			endcase
		end
	endfunction

	// Main stimulus sequence.
	initial begin
		int start_chars;
		int pick;
		sb            = new(MAX_INTEGERS);
		quiet         = 1'b0;
		calm          = 1'b0;
		texts_sent    = 0;
		settings_used = 0;
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		character <= '0;
		text_end  <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed texts: a lone number under the reset count.
		send_string(" 5", 1'b1);
		// One character that closes a number and then fails, a bad first byte, early endings.
		settle();
		write_count(5'd2);
		send_string("3x", 1'b1);
		text_buf.delete();
		text_buf.push_back(8'hFF);
		send_text(1'b1);
		send_string("8", 1'b1);
		send_string(" ", 1'b1);
		// A count of zero, a saturating number, and characters ignored after the close.
		settle();
		write_count(5'd0);
		send_string("9999999999", 1'b1);
		send_string("1 ab", 1'b1);
		// The count drops below the numbers already read in the middle of a text.
		settle();
		write_count(5'd5);
		send_string("1 2 ", 1'b0);
		settle();
		write_count(5'd1);
		send_string("3 z", 1'b1);

		// Random texts, changing the count every few texts.
		start_chars = sb.chars_noted;
		while (sb.chars_noted - start_chars < RANDOM_ITEMS) begin
			if (texts_sent % 4 == 0) begin
				settle();
				case (settings_used)
					5: write_count(5'd16);
					6: write_count(5'd31);
					7: write_count(5'd17);
					default: write_count(pick_count());
				endcase
			end
			calm = ($urandom_range(0, 2) == 0);
			pick = $urandom_range(0, 19);
			if (pick < 14) begin
				build_wellformed();
			end else if (pick < 17) begin
				build_wellformed();
				text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom);
			end else begin
				build_noise();
			end
			send_text(1'b1);
		end

		// Quiet tail: a few well-formed texts with no idling on either side.
		quiet = 1'b1;
		settle();
		write_count(5'd2);
		repeat (TAIL_TEXTS) begin
			build_wellformed();
			send_text(1'b1);
		end

		settle();
		repeat (20) @(posedge clk);
		$display("Checked %0d results from %0d characters in %0d texts.",
			sb.results_checked, sb.chars_noted, texts_sent);
		$display("The number count was written %0d times, including 0, 16 and 31.",
			settings_used);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("[space_separated_decimal_parser_top] OK");
		end else begin
			$display("[space_separated_decimal_parser_top] ERROR");
		end
		$finish;
	end

endmodule
